// ----- src/kill_packet_deframer_top_defines.svh -----
// ----------------------------------------------------------------------------
// kill_packet_deframer_top_defines
// Assertion macros shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef KILL_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define KILL_PACKET_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define KPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpd assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define KPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpd assertion failed");

`endif

// ----- src/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Types and constants of the serial kill packet deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kpd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_KILL    = 2'd1,
    ST_FRAME   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_END_BYTE      = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2
  } cfg_reg_t;

  localparam logic [0:0] OP_BYTE = 1'b0;

  localparam logic [7:0]  CHAR_K    = 8'h4B;
  localparam logic [7:0]  CHAR_ZERO = 8'h30;

  localparam logic [7:0]  START_BYTE_RST    = 8'd65;
  localparam logic [7:0]  END_BYTE_RST      = 8'd90;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

  localparam int unsigned TIMER_W = 17;

endpackage

// ----- src/kill_packet_deframer_top.sv -----
// Timing: a request is registered in the input stage at acceptance, and its
// status, if any, is registered in the result stage once that stage can take it.
// Throughput: one request per cycle while in_stall is low; the frame state updates in a single pass.
// A request that closes nothing (most bytes, most ticks) produces no status.
// Reset: synchronous, active-low rst_n restores the delimiters and timeout to
// their defaults and puts the parser back to hunting for a start byte.
// ----------------------------------------------------------------------------
// kill_packet_deframer_top
// Decodes start/length/payload/end frames from a byte and tick stream and
// reports ok, kill, framing error or timeout per frame, per stray byte and per timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kill_packet_deframer_top_defines.svh"

module kill_packet_deframer_top #(
  parameter int unsigned MAX_PAYLOAD = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  // status channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0]  MAX_DIGIT = 8'(MAX_PAYLOAD);
  localparam int unsigned TW = kpd_pkg::TIMER_W;

  // Configuration registers
  logic [7:0]  start_byte_r;
  logic [7:0]  end_byte_r;
  logic [15:0] timeout_ticks_r;

  // Input stage
  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_op_r;
  logic [7:0]  s1_byte_r;
  logic        s1_go;
  logic        s1_step;

  // Frame state
  kpd_pkg::phase_t  phase_r, phase_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             first_pending_r, first_pending_nxt;
  logic             kill_seen_r, kill_seen_nxt;
  logic [TW-1:0]    wait_timer_r, wait_timer_nxt;

  // Result stage
  logic              out_valid_r, out_valid_nxt;
  kpd_pkg::status_t  out_status_r;

  // Decode
  logic              emit;
  kpd_pkg::status_t  status;
  logic [TW-1:0]     timer_inc;
  logic [7:0]        digit_val;
  logic              digit_ok;
  logic              is_delim;
  logic [LEN_W-1:0]  bytes_dec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= kpd_pkg::START_BYTE_RST;
      end_byte_r      <= kpd_pkg::END_BYTE_RST;
      timeout_ticks_r <= kpd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kpd_pkg::CFG_START_BYTE:    start_byte_r    <= cfg_wdata[7:0];
        kpd_pkg::CFG_END_BYTE:      end_byte_r      <= cfg_wdata[7:0];
        kpd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The input stage moves on whenever the result register can take a value.
  assign s1_go    = !out_valid_r || !out_stall;
  assign s1_step  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_rx_byte;
    end
  end

  assign timer_inc = wait_timer_r + TW'(1);
  assign digit_val = s1_byte_r - kpd_pkg::CHAR_ZERO;
  assign digit_ok  = (s1_byte_r >= kpd_pkg::CHAR_ZERO) && (digit_val <= MAX_DIGIT);
  assign is_delim  = (s1_byte_r == end_byte_r) || (s1_byte_r == start_byte_r);
  assign bytes_dec = (bytes_left_r != '0) ? bytes_left_r - LEN_W'(1) : bytes_left_r;

  // Output decode: whether this request closes a frame, and with which status.
  always_comb begin
    emit   = 1'b0;
    status = kpd_pkg::ST_OK;
    if (s1_op_r != kpd_pkg::OP_BYTE) begin
      if (timer_inc > {1'b0, timeout_ticks_r}) begin
        emit   = 1'b1;
        status = kpd_pkg::ST_TIMEOUT;
      end
    end else begin
      case (phase_r)
        kpd_pkg::PH_HUNT: begin
          if (s1_byte_r != start_byte_r) begin
            emit   = 1'b1;
            status = kpd_pkg::ST_FRAME;
          end
        end
        kpd_pkg::PH_LEN: begin
          if (is_delim || !digit_ok) begin
            emit   = 1'b1;
            status = kpd_pkg::ST_FRAME;
          end
        end
        kpd_pkg::PH_DATA: begin
          if (is_delim) begin
            emit   = 1'b1;
            status = kpd_pkg::ST_FRAME;
          end
        end
        kpd_pkg::PH_END: begin
          emit = 1'b1;
          if (s1_byte_r != end_byte_r) begin
            status = kpd_pkg::ST_FRAME;
          end else if (kill_seen_r) begin
            status = kpd_pkg::ST_KILL;
          end else begin
            status = kpd_pkg::ST_OK;
          end
        end
        default: ;
      endcase
    end
  end

  // Next-state decode. Any status sends the parser back to hunting.
  always_comb begin
    phase_nxt         = phase_r;
    bytes_left_nxt    = bytes_left_r;
    first_pending_nxt = first_pending_r;
    kill_seen_nxt     = kill_seen_r;
    wait_timer_nxt    = wait_timer_r;
    if (s1_step) begin
      if (emit) begin
        phase_nxt         = kpd_pkg::PH_HUNT;
        bytes_left_nxt    = '0;
        first_pending_nxt = 1'b0;
        kill_seen_nxt     = 1'b0;
        wait_timer_nxt    = '0;
      end else if (s1_op_r != kpd_pkg::OP_BYTE) begin
        wait_timer_nxt = timer_inc;
      end else begin
        wait_timer_nxt = '0;
        case (phase_r)
          kpd_pkg::PH_HUNT: begin
            phase_nxt = kpd_pkg::PH_LEN;
          end
          kpd_pkg::PH_LEN: begin
            bytes_left_nxt = digit_val[LEN_W-1:0];
            kill_seen_nxt  = 1'b0;
            if (digit_val == 8'd0) begin
              first_pending_nxt = 1'b0;
              phase_nxt         = kpd_pkg::PH_END;
            end else begin
              first_pending_nxt = 1'b1;
              phase_nxt         = kpd_pkg::PH_DATA;
            end
          end
          kpd_pkg::PH_DATA: begin
            if (first_pending_r) begin
              kill_seen_nxt     = (s1_byte_r == kpd_pkg::CHAR_K);
              first_pending_nxt = 1'b0;
            end
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == '0) begin
              phase_nxt = kpd_pkg::PH_END;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= kpd_pkg::PH_HUNT;
      bytes_left_r    <= '0;
      first_pending_r <= 1'b0;
      kill_seen_r     <= 1'b0;
      wait_timer_r    <= '0;
    end else begin
      phase_r         <= phase_nxt;
      bytes_left_r    <= bytes_left_nxt;
      first_pending_r <= first_pending_nxt;
      kill_seen_r     <= kill_seen_nxt;
      wait_timer_r    <= wait_timer_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = s1_step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_step && emit) begin
      out_status_r <= status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  `KPD_ASSERT_NOW(a_timer_bound, 1'b1, wait_timer_r <= 17'h10000)
  `KPD_ASSERT_NOW(a_count_in_data, phase_r != kpd_pkg::PH_DATA, bytes_left_r == '0)
  `KPD_ASSERT_NOW(a_first_in_data, first_pending_r, phase_r == kpd_pkg::PH_DATA)
  `KPD_ASSERT_NOW(a_result_has_source, out_valid_r && !$past(out_valid_r), $past(s1_step))
  `KPD_ASSERT_NEXT(a_stall_keeps_item, s1_valid_r && in_stall, s1_valid_r)

endmodule
